/* hw/rtl/ojs_pkg.sv */
// Package for the overlapping job splitter: datapath widths, parameter
// defaults and the sequencer state type. No dependencies.
package ojs_pkg;

  // Working width of the serial divider and the coordinate arithmetic.
  localparam int DW = 34;

  localparam int ENGINES_DEF        = 8;
  localparam int BLOCK_LEN_DEF      = 128;
  localparam int MIN_JOB_BLOCKS_DEF = 50;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_GO,
    S_DSTART,
    S_DJOBS,
    S_DSHARE,
    S_JOB,
    S_DFIRST,
    S_DLAST,
    S_OUT
  } ojs_state_t;

endpackage

/* hw/rtl/ojs_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on ojs_pkg for the working width.
module ojs_div
  import ojs_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quot,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(DW);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW-1:0] dvd_r, dvd_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW:0]   trial;
  logic          qbit;

  always_comb begin
    trial    = {rem_r, dvd_r[DW-1]};
    qbit     = (trial >= {1'b0, dvs_r});
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (start) begin
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // The partial remainder stays below the divisor, so it fits DW bits.
      rem_nxt = qbit ? DW'(trial - {1'b0, dvs_r}) : DW'(trial);
      dvd_nxt = {dvd_r[DW-2:0], qbit};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = dvd_r;
  assign rem  = rem_r;

endmodule

/* hw/rtl/overlapping_job_splitter_unit.sv */
// Overlapping job splitter: one region word in, one word per job out.
// One serial divider runs setup (start mod block, bank / min length, bank /
// jobs), then per job its first block and, if not empty, its last block.
// One region at a time; the next is taken after the last job word leaves.
// Reset (synchronous, rst_n low) returns the sequencer to idle.
module overlapping_job_splitter_unit
  import ojs_pkg::*;
#(
  parameter int ENGINES        = ENGINES_DEF,
  parameter int BLOCK_LEN      = BLOCK_LEN_DEF,
  parameter int MIN_JOB_BLOCKS = MIN_JOB_BLOCKS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // region_start, region_end, tail_overlap, bank_block_base, device_id,
  // query_length
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_device, engine_index, job_offset, job_length, overlap_start,
  // first_block, block_count
  output logic [167:0] out_tdata,
  output logic         out_tlast
);

  localparam int JW = $clog2(ENGINES + 1);
  localparam int SW = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam logic [DW-1:0] BLK   = DW'(BLOCK_LEN);
  localparam logic [DW-1:0] FLOOR = DW'(MIN_JOB_BLOCKS * BLOCK_LEN);
  localparam logic [DW-1:0] M32   = DW'(64'hFFFF_FFFF);

  ojs_state_t state_r, state_nxt;

  logic [31:0]   start_r, end_r, base_r;
  logic [19:0]   tail_r;
  logic [3:0]    dev_r;
  logic [15:0]   qlen_r;
  logic [DW-1:0] bank_r, minl_r, share_r, cum_r, off_r, split_r, len_r, first_r;
  logic [JW-1:0] jobs_r, remj_r, j_r;
  logic [SW-1:0] sr_r;
  logic [167:0]  odata_r;
  logic          olast_r;

  logic          div_go, div_done;
  logic [DW-1:0] div_dvd, div_dvs, div_quot, div_rem;

  logic [DW-1:0] two_q, diff, split_c, ovl_c, cnt_c;
  logic [JW-1:0] jobs_c;
  logic          last_c, ld_out;

  ojs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign two_q   = DW'({qlen_r, 1'b0});
  assign last_c  = (j_r == jobs_r - 1'b1);
  assign split_c = share_r + DW'(j_r < remj_r);
  assign ovl_c   = (off_r + split_r > DW'(end_r)) ? DW'(end_r) : off_r + split_r;
  assign cnt_c   = div_quot - first_r + 1'b1;

  always_comb begin
    if (div_quot == '0) jobs_c = JW'(1);
    else if (div_quot > DW'(ENGINES)) jobs_c = JW'(ENGINES);
    else jobs_c = JW'(div_quot);
    diff = (end_r >= start_r) ? DW'(end_r - start_r) : '0;
  end

  always_comb begin
    state_nxt = state_r;
    div_go    = 1'b0;
    div_dvd   = DW'(start_r);
    div_dvs   = BLK;
    ld_out    = 1'b0;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_PREP;
      S_PREP:  state_nxt = S_GO;
      S_GO: begin
        // Start coordinate modulo the block length comes first.
        div_go    = 1'b1;
        state_nxt = S_DSTART;
      end
      S_DSTART: if (div_done) begin
        div_go    = 1'b1;
        div_dvd   = bank_r;
        div_dvs   = minl_r;
        state_nxt = S_DJOBS;
      end
      S_DJOBS: if (div_done) state_nxt = S_DSHARE;
      S_DSHARE: begin
        // Bank / jobs was launched on the way in; wait for it here.
        if (div_done) state_nxt = S_JOB;
      end
      S_JOB: begin
        div_go    = 1'b1;
        div_dvd   = cum_r + DW'(sr_r);
        state_nxt = S_DFIRST;
      end
      S_DFIRST: if (div_done) begin
        if (len_r == '0) begin
          ld_out    = 1'b1;
          state_nxt = S_OUT;
        end else begin
          div_go    = 1'b1;
          div_dvd   = cum_r + DW'(sr_r) + len_r - 1'b1;
          state_nxt = S_DLAST;
        end
      end
      S_DLAST: if (div_done) begin
        ld_out    = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: if (out_tready) state_nxt = last_c ? S_IDLE : S_JOB;
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_DJOBS && div_done) begin
      div_go  = 1'b1;
      div_dvd = bank_r;
      div_dvs = DW'(jobs_c);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      start_r <= in_tdata[31:0];
      end_r   <= in_tdata[63:32];
      tail_r  <= in_tdata[83:64];
      base_r  <= in_tdata[115:84];
      dev_r   <= in_tdata[119:116];
      qlen_r  <= in_tdata[135:120];
    end
    if (state_r == S_PREP) begin
      bank_r <= diff + DW'(tail_r);
      minl_r <= (two_q > FLOOR) ? two_q : FLOOR;
      cum_r  <= '0;
      j_r    <= '0;
    end
    if (state_r == S_DSTART && div_done) sr_r <= SW'(div_rem);
    if (state_r == S_DJOBS && div_done) jobs_r <= jobs_c;
    if (state_r == S_DSHARE && div_done) begin
      share_r <= div_quot;
      remj_r  <= JW'(div_rem);
    end
    if (state_r == S_JOB) begin
      split_r <= split_c;
      len_r   <= last_c ? split_c : split_c + two_q;
      off_r   <= DW'(start_r) + cum_r;
    end
    if (state_r == S_DFIRST && div_done) first_r <= div_quot;
    if (ld_out) begin
      odata_r[3:0]     <= dev_r;
      odata_r[6:4]     <= 3'(j_r);
      odata_r[38:7]    <= (off_r > M32) ? 32'hFFFF_FFFF : off_r[31:0];
      odata_r[71:39]   <= len_r[DW-1] ? {33{1'b1}} : len_r[32:0];
      odata_r[103:72]  <= ovl_c[31:0];
      odata_r[135:104] <= (state_r == S_DFIRST) ? div_quot[31:0] + base_r
                                                : first_r[31:0] + base_r;
      odata_r[167:136] <= (state_r == S_DFIRST) ? 32'd0 :
                          (cnt_c > M32) ? 32'hFFFF_FFFF : cnt_c[31:0];
      olast_r          <= last_c;
    end
    if (state_r == S_OUT && out_tready) begin
      cum_r <= cum_r + split_r;
      j_r   <= j_r + 1'b1;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while a job word waits");
  a_job_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (j_r < jobs_r)) else $error("job index past job count");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DSTART || state_r == S_DJOBS || state_r == S_DSHARE ||
                  state_r == S_DFIRST || state_r == S_DLAST))
    else $error("divider finished outside a wait state");

endmodule
